/* src/cflb_pkg.sv */
// shared types, constants and coefficient table of the circular fir buffer
package cflb_pkg;

  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned AddrW      = $clog2(MaxSamples);
  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned TapCount   = 199;
  localparam int unsigned HalfTaps   = 100;
  localparam int unsigned CoefW      = 20;
  localparam int unsigned AccW       = 36;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdFetch = 1'b1;

  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatTrunc  = 2'd1;
  localparam logic [1:0] StatNoData = 2'd2;

  // pair scan phases while building the averaged sequence
  localparam logic [1:0] PhEven = 2'd0;
  localparam logic [1:0] PhWrap = 2'd1;
  localparam logic [1:0] PhOdd  = 2'd2;
  localparam logic [1:0] PhDone = 2'd3;

  typedef struct packed {
    logic       command;
    logic [7:0] sample;
    logic       last_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] filtered_value;
    logic       final_output;
    logic [1:0] status;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic wr_copy;
    logic build_init;
    logic rd_a;
    logic rd_b;
    logic pair_wr;
    logic fin_build;
    logic fir_step;
    logic emit_ok;
    logic emit_nodata;
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic ready;
    logic last;
    logic copy_last;
    logic pair_avail;
    logic tap_last;
    logic pipe_empty;
    logic out_free;
  } sts_t;

  localparam logic signed [CoefW-1:0] LpHalf [HalfTaps] = '{
    20'sd173, 20'sd119, 20'sd57, -20'sd13, -20'sd92, -20'sd181, -20'sd277, -20'sd381,
    -20'sd493, -20'sd614, -20'sd740, -20'sd872, -20'sd1008, -20'sd1148, -20'sd1287,
    -20'sd1426, -20'sd1560, -20'sd1689, -20'sd1808, -20'sd1916, -20'sd2005, -20'sd2074,
    -20'sd2116, -20'sd2127, -20'sd2104, -20'sd2038, -20'sd1926, -20'sd1758, -20'sd1532,
    -20'sd1236, -20'sd866, -20'sd414, 20'sd128, 20'sd768, 20'sd1515, 20'sd2376,
    20'sd3359, 20'sd4471, 20'sd5723, 20'sd7122, 20'sd8674, 20'sd10388, 20'sd12273,
    20'sd14334, 20'sd16578, 20'sd19010, 20'sd21638, 20'sd24465, 20'sd27496, 20'sd30736,
    20'sd34185, 20'sd37848, 20'sd41723, 20'sd45815, 20'sd50119, 20'sd54633, 20'sd59359,
    20'sd64289, 20'sd69419, 20'sd74742, 20'sd80254, 20'sd85943, 20'sd91803, 20'sd97821,
    20'sd103987, 20'sd110287, 20'sd116707, 20'sd123234, 20'sd129852, 20'sd136543,
    20'sd143291, 20'sd150076, 20'sd156880, 20'sd163685, 20'sd170470, 20'sd177214,
    20'sd183897, 20'sd190495, 20'sd196990, 20'sd203360, 20'sd209583, 20'sd215636,
    20'sd221501, 20'sd227158, 20'sd232584, 20'sd237762, 20'sd242672, 20'sd247298,
    20'sd251620, 20'sd255623, 20'sd259292, 20'sd262614, 20'sd265575, 20'sd268165,
    20'sd270375, 20'sd272194, 20'sd273615, 20'sd274635, 20'sd275249, 20'sd275453
  };

  // symmetric tap lookup
  function automatic logic signed [CoefW-1:0] tap_coef(input logic [7:0] j);
    logic [7:0] h;
    h = (j < 8'(HalfTaps)) ? j : 8'(TapCount - 1) - j;
    return LpHalf[h[6:0]];
  endfunction

endpackage

/* src/circular_fir_lowpass_buffer_top.sv */
// top level of the circular 199-tap low-pass fir buffer
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (out_t)
//  cfg     | input     | cfg_we_i              | cfg_data_i (repeat_ratio)
//
// a load makes one store write per copy; the final load then builds each
// averaged value from two reads and a pair write, set by the single read
// port of the resampled store. a fetch runs 199 taps through one shared
// mac, drains the mac pipeline and loads the output register.
// reset clears control state only; the stores hold no reset value.
// a held output stalls the next fetch at its emit step, not its acceptance.
module circular_fir_lowpass_buffer_top
  import cflb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  ctl_t ctl;
  sts_t sts;

  // controller
  cflb_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .ctl_o        (ctl)
  );

  // datapath
  cflb_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* src/cflb_datapath.sv */
// stores, counters, pair averager, mac pipeline and output register
module cflb_datapath
  import cflb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [12:0]   cfg_data_i,
  input  in_t           in_data_i,
  input  ctl_t          ctl_i,
  output sts_t          sts_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_t          out_data_o
);

  logic [12:0]      ratio_q;
  logic [CntW-1:0]  cnt_q, len_q, oidx_q, ai_q, k_q, rep_q;
  logic             trunc_q, ready_q, last_q;
  logic [7:0]       sample_q;
  logic [1:0]       ph_q;
  logic [7:0]       ra_q, rs_rd_q, av_rd_q;
  logic [7:0]       j_q;
  logic [AddrW-1:0] fidx_q;
  logic signed [CoefW-1:0] coef_q;
  logic signed [CoefW+8:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic             v1_q, v2_q;
  logic             out_valid_q;
  out_t             out_q;

  logic [7:0] rs_mem [MaxSamples];
  logic [7:0] av_mem [MaxSamples];

  // current pair addresses
  logic [CntW-1:0] pa, pb, ai_n;
  logic            odd_n;
  always_comb begin
    odd_n = cnt_q[0];
    ai_n  = ai_q + CntW'(2);
    if (ph_q == PhWrap) begin
      pa = cnt_q - CntW'(1);
      pb = '0;
    end else begin
      pa = ai_q;
      pb = ai_q + CntW'(1);
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= 13'd1;
    end else if (cfg_we_i) begin
      ratio_q <= cfg_data_i;
    end
  end

  // load, build and index control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      len_q   <= '0;
      oidx_q  <= '0;
      trunc_q <= 1'b0;
      ready_q <= 1'b0;
      rep_q   <= '0;
      ai_q    <= '0;
      k_q     <= '0;
      ph_q    <= PhDone;
      last_q  <= 1'b0;
    end else begin
      if (ctl_i.start && in_data_i.command == CmdLoad) begin
        rep_q  <= (ratio_q == 13'd0) ? CntW'(1) : CntW'(ratio_q);
        last_q <= in_data_i.last_sample;
        if (ready_q) begin
          cnt_q   <= '0;
          len_q   <= '0;
          oidx_q  <= '0;
          trunc_q <= 1'b0;
          ready_q <= 1'b0;
        end
      end
      if (ctl_i.wr_copy) begin
        rep_q <= rep_q - CntW'(1);
        if (cnt_q < CntW'(MaxSamples)) cnt_q <= cnt_q + CntW'(1);
        else trunc_q <= 1'b1;
      end
      if (ctl_i.build_init) begin
        ai_q <= '0;
        k_q  <= '0;
        if (cnt_q > CntW'(1)) ph_q <= PhEven;
        else if (odd_n) ph_q <= PhWrap;
        else ph_q <= PhDone;
      end
      if (ctl_i.pair_wr) begin
        k_q <= k_q + CntW'(1);
        case (ph_q)
          PhEven: begin
            ai_q <= ai_n;
            if (!(ai_n + CntW'(1) < cnt_q)) ph_q <= odd_n ? PhWrap : PhDone;
          end
          PhWrap: begin
            ai_q <= CntW'(1);
            ph_q <= (CntW'(2) < cnt_q) ? PhOdd : PhDone;
          end
          PhOdd: begin
            ai_q <= ai_n;
            if (!(ai_n + CntW'(1) < cnt_q)) ph_q <= PhDone;
          end
          default: ph_q <= PhDone;
        endcase
      end
      if (ctl_i.fin_build) begin
        len_q   <= k_q;
        oidx_q  <= '0;
        ready_q <= (k_q != '0);
      end
      if (ctl_i.emit_ok) begin
        oidx_q <= (oidx_q + CntW'(1) >= len_q) ? '0 : oidx_q + CntW'(1);
      end
    end
  end

  // sample latch
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) sample_q <= in_data_i.sample;
  end

  // resampled store
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_copy && cnt_q < CntW'(MaxSamples)) rs_mem[cnt_q[AddrW-1:0]] <= sample_q;
    if (ctl_i.rd_a) rs_rd_q <= rs_mem[pa[AddrW-1:0]];
    if (ctl_i.rd_b) begin
      rs_rd_q <= rs_mem[pb[AddrW-1:0]];
      ra_q    <= rs_rd_q;
    end
  end

  // averaged store, written by the pair averager and read by the mac
  logic [8:0] pair_sum;
  assign pair_sum = {1'b0, ra_q} + {1'b0, rs_rd_q};
  always_ff @(posedge clk_i) begin
    if (ctl_i.pair_wr) av_mem[k_q[AddrW-1:0]] <= pair_sum[8:1];
    if (ctl_i.fir_step) av_rd_q <= av_mem[fidx_q];
  end

  // tap sequencing and mac pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctl_i.fir_step;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      j_q    <= '0;
      fidx_q <= oidx_q[AddrW-1:0];
      acc_q  <= '0;
    end else begin
      if (ctl_i.fir_step) begin
        coef_q <= tap_coef(j_q);
        j_q    <= j_q + 8'd1;
        fidx_q <= (fidx_q == '0) ? AddrW'(len_q - CntW'(1)) : fidx_q - AddrW'(1);
      end
      if (v1_q) prod_q <= coef_q * $signed({1'b0, av_rd_q});
      if (v2_q) acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // rounding half away from zero and saturation
  logic [AccW-1:0] rnd;
  logic [7:0]      fval;
  always_comb begin
    rnd = AccW'(acc_q) + AccW'(1 << 23);
    if (acc_q <= 0) fval = 8'd0;
    else if (rnd[AccW-1:32] != '0) fval = 8'd255;
    else fval = rnd[31:24];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.emit_ok || ctl_i.emit_nodata) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit_ok) begin
      out_q.filtered_value <= fval;
      out_q.final_output   <= (oidx_q + CntW'(1) == len_q);
      out_q.status         <= trunc_q ? StatTrunc : StatOk;
    end else if (ctl_i.emit_nodata) begin
      out_q.filtered_value <= 8'd0;
      out_q.final_output   <= 1'b0;
      out_q.status         <= StatNoData;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // status to the controller
  always_comb begin
    sts_o.ready      = ready_q;
    sts_o.last       = last_q;
    sts_o.copy_last  = (rep_q == CntW'(1));
    sts_o.pair_avail = (ph_q != PhDone);
    sts_o.tap_last   = (j_q == 8'(TapCount - 1));
    sts_o.pipe_empty = !v1_q && !v2_q;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

/* src/cflb_ctrl.sv */
// sequencing state machine for load, build and fetch
module cflb_ctrl
  import cflb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_command_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output ctl_t ctl_o
);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SLoad  = 4'd1;
  localparam logic [3:0] SBinit = 4'd2;
  localparam logic [3:0] SAva   = 4'd3;
  localparam logic [3:0] SAvb   = 4'd4;
  localparam logic [3:0] SAvw   = 4'd5;
  localparam logic [3:0] SFir   = 4'd6;
  localparam logic [3:0] SDrain = 4'd7;
  localparam logic [3:0] SEmit  = 4'd8;
  localparam logic [3:0] SEmitN = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          if (in_command_i == CmdLoad) state_d = SLoad;
          else state_d = sts_i.ready ? SFir : SEmitN;
        end
      end
      SLoad: begin
        ctl_o.wr_copy = 1'b1;
        if (sts_i.copy_last) state_d = sts_i.last ? SBinit : SIdle;
      end
      SBinit: begin
        ctl_o.build_init = 1'b1;
        state_d = SAva;
      end
      SAva: begin
        if (sts_i.pair_avail) begin
          ctl_o.rd_a = 1'b1;
          state_d = SAvb;
        end else begin
          ctl_o.fin_build = 1'b1;
          state_d = SIdle;
        end
      end
      SAvb: begin
        ctl_o.rd_b = 1'b1;
        state_d = SAvw;
      end
      SAvw: begin
        ctl_o.pair_wr = 1'b1;
        state_d = SAva;
      end
      SFir: begin
        ctl_o.fir_step = 1'b1;
        if (sts_i.tap_last) state_d = SDrain;
      end
      SDrain: begin
        if (sts_i.pipe_empty) state_d = SEmit;
      end
      SEmit: begin
        if (sts_i.out_free) begin
          ctl_o.emit_ok = 1'b1;
          state_d = SIdle;
        end
      end
      SEmitN: begin
        if (sts_i.out_free) begin
          ctl_o.emit_nodata = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  // a filter pass only runs over a ready buffer
  a_fir_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SFir |-> sts_i.ready) else $error("filter pass without ready buffer");

  // a pair write always follows the second read
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SAvw |-> $past(state_q) == SAvb) else $error("pair write out of order");

  // a result leaves as soon as the output slot is free
  a_emit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEmit || state_q == SEmitN) && sts_i.out_free |=> state_q == SIdle)
    else $error("emit did not complete");

endmodule
